// ----- hw/rtl/llci_pkg.sv -----
// ----------------------------------------------------------------------------
// llci_pkg
// Types, widths and codes for the lookahead line/circle intersection block.
// ----------------------------------------------------------------------------
package llci_pkg;

  localparam int CW   = 24;               // coordinate width
  localparam int DW   = CW + 1;           // coordinate difference width
  localparam int PW   = 2 * DW;           // product of two differences
  localparam int LW   = 2 * CW + 1;       // squared segment length
  localparam int RS   = CW - 1;           // radius width
  localparam int R2W  = 2 * RS;           // squared radius
  localparam int SPL  = DW;               // low split of wide operands
  localparam int SQN  = (R2W + LW + 1) / 2;  // root bits
  localparam int RADW = 2 * SQN;          // radicand width
  localparam int RMW  = SQN + 4;          // root remainder width
  localparam int QL   = SQN / 2;          // low split of the root
  localparam int PPW  = 2 * DW + 1;       // partial product width
  localparam int TW   = PW + DW + 1;      // numerator width
  localparam int NW   = TW + 1;           // dividend width
  localparam int DQW  = CW + 1;           // quotient bits
  localparam int PXW  = CW + 3;           // unsaturated target width
  localparam int EW   = PXW + 2;          // Manhattan distance width

  typedef logic signed [CW-1:0]  coord_t;
  typedef logic        [RS-1:0]  radius_t;
  typedef logic signed [DW-1:0]  diff_t;
  typedef logic signed [PW-1:0]  prod_t;
  typedef logic signed [TW-1:0]  num_t;
  typedef logic signed [PXW-1:0] pos_t;

  localparam pos_t CMAX = pos_t'((2 ** (CW - 1)) - 1);
  localparam pos_t CMIN = -CMAX - pos_t'(1);

  typedef enum logic [1:0] {
    ST_FOUND   = 2'd0,
    ST_NO_ROOT = 2'd1,
    ST_OUTSIDE = 2'd2
  } status_t;

  typedef struct packed {
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    coord_t rx;
    coord_t ry;
  } pts_t;

  typedef struct packed {
    pts_t            pts;
    prod_t           c;
    logic [LW-1:0]   l;
    diff_t           dx;
    diff_t           dy;
    logic            nosol;
  } sqc_t;

  typedef struct packed {
    pts_t            pts;
    logic [LW-1:0]   l;
    logic            nosol;
    logic            dxneg;
  } dvc_t;

endpackage

// ----- hw/rtl/llci_in_if.sv -----
// ----------------------------------------------------------------------------
// llci_in_if
// Input item channel: segment, lookahead radius and robot position.
// ----------------------------------------------------------------------------
interface llci_in_if;
  logic              valid;
  logic              ready;
  llci_pkg::coord_t  start_x;
  llci_pkg::coord_t  start_y;
  llci_pkg::coord_t  end_x;
  llci_pkg::coord_t  end_y;
  llci_pkg::radius_t circle_radius;
  llci_pkg::coord_t  robot_x;
  llci_pkg::coord_t  robot_y;

  modport source (output valid, start_x, start_y, end_x, end_y, circle_radius,
                  robot_x, robot_y, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, circle_radius,
                  robot_x, robot_y, output ready);
endinterface

// ----- hw/rtl/llci_out_if.sv -----
// ----------------------------------------------------------------------------
// llci_out_if
// Result item channel: chosen target point and status.
// ----------------------------------------------------------------------------
interface llci_out_if;
  logic              valid;
  logic              ready;
  llci_pkg::coord_t  target_x;
  llci_pkg::coord_t  target_y;
  llci_pkg::status_t status;

  modport source (output valid, target_x, target_y, status, input ready);
  modport sink   (input valid, target_x, target_y, status, output ready);
endinterface

// ----- hw/rtl/lookahead_line_circle_intersect.sv -----
// ----------------------------------------------------------------------------
// lookahead_line_circle_intersect
// Intersects the line through a path segment with the lookahead circle
// around the robot and picks the target point.
//
// in_ch carries one item per segment query; out_ch returns one result item
// per input item, in order. Both are valid/ready channels.
// Throughput: one item per cycle while out_ch does not stall. The 48-stage root
// pipeline and four 25-stage divider pipelines each take a new item every cycle unless stalled.
// Status 1 means the line misses the circle, status 2 means both points lie
// outside the segment span; targets are zero then.
// Reset clears all stage valid bits; no item is in flight afterwards.
// When out_ch.ready is low with a result waiting, the whole pipeline holds
// and in_ch.ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module lookahead_line_circle_intersect (
  input  logic       clk,
  input  logic       rst_n,
  llci_in_if.sink    in_ch,
  llci_out_if.source out_ch
);
  import llci_pkg::*;

  logic adv;

  // stage 1: differences
  logic    v1_r;
  pts_t    pts1_r;
  radius_t r1_r;
  diff_t   ax1_r, ay1_r, dx1_r, dy1_r;
  diff_t   dx_c, dy_c;

  // stage 2: products
  logic              v2_r;
  pts_t              pts2_r;
  prod_t             p1_r, p2_r;
  logic [2*CW-1:0]   sqx_r, sqy_r;
  logic [R2W-1:0]    r2_2_r;
  diff_t             dx2_r, dy2_r;
  prod_t             sqx_c, sqy_c;

  // stage 3: C, |C|, L
  logic              v3_r;
  pts_t              pts3_r;
  prod_t             c3_r;
  logic [PW-2:0]     cm3_r;
  logic [LW-1:0]     l3_r;
  logic [R2W-1:0]    r2_3_r;
  diff_t             dx3_r, dy3_r;
  prod_t             c_c;

  // stage 4: partial products of C^2 and r^2*L
  logic              v4_r;
  sqc_t              c4_r;
  logic [2*SPL-1:0]  pll_r, plh_r, phh_r, q00_r, q01_r, q10_r, q11_r;

  // stage 5: wide sums
  logic              v5_r;
  sqc_t              c5_r;
  logic [RADW-1:0]   c2_r, r2l_r;

  // root pipeline
  logic [SQN:0]      sq_v_r;
  logic [RMW-1:0]    sq_rem_r  [SQN+1];
  logic [SQN-1:0]    sq_root_r [SQN+1];
  logic [RADW-1:0]   sq_rad_r  [SQN+1];
  sqc_t              sq_c_r    [SQN+1];
  sqc_t              sq_in_c;

  // stage 7: numerator partials
  logic              v7_r;
  sqc_t              c7_r;
  logic signed [PPW-1:0] cldy_r, chdy_r, cldx_r, chdx_r;
  logic signed [PPW-1:0] qldx_r, qhdx_r, qldy_r, qhdy_r;

  // stage 8: full products
  logic              v8_r;
  dvc_t              c8_r;
  num_t              t1_r, t2_r, t3_r, t4_r;

  // stage 9: numerators
  logic              v9_r;
  dvc_t              c9_r;
  num_t              n9_r [4];

  // divider pipelines, lanes: x plus, x minus, y plus, y minus
  logic [DQW:0]      dv_v_r;
  logic [NW-1:0]     dv_rem_r [DQW+1][4];
  logic [DQW-1:0]    dv_quo_r [DQW+1][4];
  logic [3:0]        dv_neg_r [DQW+1];
  dvc_t              dv_c_r   [DQW+1];

  // final stages
  logic              vf1_r;
  dvc_t              cf1_r;
  pos_t              pf1_r [4];
  logic              vf2_r;
  status_t           stf2_r;
  pos_t              ax_s1_r, ay_s1_r, ax_s2_r, ay_s2_r;
  logic [EW-1:0]     e1_r, e2_r;
  logic              out_valid_r;
  coord_t            out_tx_r, out_ty_r;
  status_t           out_status_r;

  function automatic logic outside(input pos_t v, input coord_t a, input coord_t b);
    pos_t pa, pb;
    pa = pos_t'(a);
    pb = pos_t'(b);
    return (v < pa && v < pb) || (v > pa && v > pb);
  endfunction

  function automatic logic [PXW:0] absd(input coord_t a, input pos_t v);
    logic signed [PXW:0] d;
    d = (PXW+1)'(a) - (PXW+1)'(v);
    return (d < 0) ? (PXW+1)'(-d) : (PXW+1)'(d);
  endfunction

  function automatic coord_t sat(input pos_t v);
    if (v > CMAX) return CMAX[CW-1:0];
    if (v < CMIN) return CMIN[CW-1:0];
    return v[CW-1:0];
  endfunction

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  // ---- stage 1
  always_comb begin
    dx_c = diff_t'(in_ch.end_x) - diff_t'(in_ch.start_x);
    dy_c = diff_t'(in_ch.end_y) - diff_t'(in_ch.start_y);
    if (dx_c == '0 && dy_c == '0) begin
      dx_c = diff_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= in_ch.valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pts1_r <= '{in_ch.start_x, in_ch.start_y, in_ch.end_x, in_ch.end_y,
                  in_ch.robot_x, in_ch.robot_y};
      r1_r   <= in_ch.circle_radius;
      ax1_r  <= diff_t'(in_ch.start_x) - diff_t'(in_ch.robot_x);
      ay1_r  <= diff_t'(in_ch.start_y) - diff_t'(in_ch.robot_y);
      dx1_r  <= dx_c;
      dy1_r  <= dy_c;
    end
  end

  // ---- stage 2
  assign sqx_c = dx1_r * dx1_r;
  assign sqy_c = dy1_r * dy1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pts2_r <= pts1_r;
      p1_r   <= ax1_r * dy1_r;
      p2_r   <= ay1_r * dx1_r;
      sqx_r  <= sqx_c[2*CW-1:0];
      sqy_r  <= sqy_c[2*CW-1:0];
      r2_2_r <= R2W'(r1_r) * R2W'(r1_r);
      dx2_r  <= dx1_r;
      dy2_r  <= dy1_r;
    end
  end

  // ---- stage 3
  assign c_c = p1_r - p2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (adv) v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pts3_r <= pts2_r;
      c3_r   <= c_c;
      cm3_r  <= (c_c < 0) ? (PW-1)'(-c_c) : (PW-1)'(c_c);
      l3_r   <= LW'(sqx_r) + LW'(sqy_r);
      r2_3_r <= r2_2_r;
      dx3_r  <= dx2_r;
      dy3_r  <= dy2_r;
    end
  end

  // ---- stage 4
  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (adv) v4_r <= v3_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c4_r  <= '{pts3_r, c3_r, l3_r, dx3_r, dy3_r, 1'b0};
      pll_r <= (2*SPL)'(cm3_r[SPL-1:0]) * (2*SPL)'(cm3_r[SPL-1:0]);
      plh_r <= (2*SPL)'(cm3_r[SPL-1:0]) * (2*SPL)'(cm3_r[PW-2:SPL]);
      phh_r <= (2*SPL)'(cm3_r[PW-2:SPL]) * (2*SPL)'(cm3_r[PW-2:SPL]);
      q00_r <= (2*SPL)'(r2_3_r[RS-1:0]) * (2*SPL)'(l3_r[SPL-1:0]);
      q01_r <= (2*SPL)'(r2_3_r[RS-1:0]) * (2*SPL)'(l3_r[LW-1:SPL]);
      q10_r <= (2*SPL)'(r2_3_r[R2W-1:RS]) * (2*SPL)'(l3_r[SPL-1:0]);
      q11_r <= (2*SPL)'(r2_3_r[R2W-1:RS]) * (2*SPL)'(l3_r[LW-1:SPL]);
    end
  end

  // ---- stage 5
  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (adv) v5_r <= v4_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c5_r  <= c4_r;
      c2_r  <= (RADW'(phh_r) << (2*SPL)) + (RADW'(plh_r) << (SPL+1)) + RADW'(pll_r);
      r2l_r <= (RADW'(q11_r) << (RS+SPL)) + (RADW'(q01_r) << SPL)
             + (RADW'(q10_r) << RS) + RADW'(q00_r);
    end
  end

  // ---- stage 6: existence test, root pipeline entry
  always_comb begin
    sq_in_c       = c5_r;
    sq_in_c.nosol = (r2l_r < c2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sq_v_r[0] <= 1'b0;
    else if (adv) sq_v_r[0] <= v5_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_c_r[0]       <= sq_in_c;
      sq_rad_r[0]     <= (r2l_r < c2_r) ? '0 : r2l_r - c2_r;
      sq_rem_r[0]     <= '0;
      sq_root_r[0]    <= '0;
    end
  end

  // ---- root pipeline, two radicand bits per stage
  for (genvar k = 0; k < SQN; k++) begin : g_sq
    logic [RMW-1:0] rem_sh, trial;
    logic           ge;

    assign rem_sh = {sq_rem_r[k][RMW-3:0], sq_rad_r[k][RADW-1 -: 2]};
    assign trial  = {{(RMW-SQN-2){1'b0}}, sq_root_r[k], 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) sq_v_r[k+1] <= 1'b0;
      else if (adv) sq_v_r[k+1] <= sq_v_r[k];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_c_r[k+1]    <= sq_c_r[k];
        sq_rad_r[k+1]  <= sq_rad_r[k] << 2;
        sq_rem_r[k+1]  <= ge ? rem_sh - trial : rem_sh;
        sq_root_r[k+1] <= {sq_root_r[k][SQN-2:0], ge};
      end
    end
  end

  // ---- stage 7: numerator partial products
  logic signed [SPL:0]   clo_c;
  logic signed [DW-1:0]  chi_c;
  logic signed [QL:0]    qlo_c, qhi_c;
  sqc_t                  cs_c;

  assign cs_c  = sq_c_r[SQN];
  assign clo_c = $signed({1'b0, cs_c.c[SPL-1:0]});
  assign chi_c = cs_c.c[PW-1:SPL];
  assign qlo_c = $signed({1'b0, sq_root_r[SQN][QL-1:0]});
  assign qhi_c = $signed({1'b0, sq_root_r[SQN][SQN-1:QL]});

  always_ff @(posedge clk) begin
    if (!rst_n) v7_r <= 1'b0;
    else if (adv) v7_r <= sq_v_r[SQN];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c7_r   <= cs_c;
      cldy_r <= PPW'(clo_c) * PPW'(cs_c.dy);
      chdy_r <= PPW'(chi_c) * PPW'(cs_c.dy);
      cldx_r <= PPW'(clo_c) * PPW'(cs_c.dx);
      chdx_r <= PPW'(chi_c) * PPW'(cs_c.dx);
      qldx_r <= PPW'(qlo_c) * PPW'(cs_c.dx);
      qhdx_r <= PPW'(qhi_c) * PPW'(cs_c.dx);
      qldy_r <= PPW'(qlo_c) * PPW'(cs_c.dy);
      qhdy_r <= PPW'(qhi_c) * PPW'(cs_c.dy);
    end
  end

  // ---- stage 8: C*dy, C*dx, Q*dx, Q*dy
  always_ff @(posedge clk) begin
    if (!rst_n) v8_r <= 1'b0;
    else if (adv) v8_r <= v7_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c8_r <= '{c7_r.pts, c7_r.l, c7_r.nosol, c7_r.dx < 0};
      t1_r <= (num_t'(chdy_r) <<< SPL) + num_t'(cldy_r);
      t2_r <= (num_t'(chdx_r) <<< SPL) + num_t'(cldx_r);
      t3_r <= (num_t'(qhdx_r) <<< QL) + num_t'(qldx_r);
      t4_r <= (num_t'(qhdy_r) <<< QL) + num_t'(qldy_r);
    end
  end

  // ---- stage 9: numerators of both roots
  always_ff @(posedge clk) begin
    if (!rst_n) v9_r <= 1'b0;
    else if (adv) v9_r <= v8_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c9_r    <= c8_r;
      n9_r[0] <= t1_r + t3_r;
      n9_r[1] <= t1_r - t3_r;
      n9_r[2] <= t4_r - t2_r;
      n9_r[3] <= -t2_r - t4_r;
    end
  end

  // ---- stage 10: rounding dividends 2|n| + L, divider entry
  always_ff @(posedge clk) begin
    if (!rst_n) dv_v_r[0] <= 1'b0;
    else if (adv) dv_v_r[0] <= v9_r;
  end

  for (genvar j = 0; j < 4; j++) begin : g_dv_in
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_neg_r[0][j] <= n9_r[j] < 0;
        dv_quo_r[0][j] <= '0;
        dv_rem_r[0][j] <= (n9_r[j] < 0)
                        ? NW'(c9_r.l) - (NW'(n9_r[j]) <<< 1)
                        : NW'(c9_r.l) + (NW'(n9_r[j]) <<< 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) dv_c_r[0] <= c9_r;
  end

  // ---- divider pipelines, one quotient bit per stage
  for (genvar i = 0; i < DQW; i++) begin : g_dv
    logic [NW-1:0] dsh;

    assign dsh = NW'({dv_c_r[i].l, 1'b0}) << (DQW - 1 - i);

    always_ff @(posedge clk) begin
      if (!rst_n) dv_v_r[i+1] <= 1'b0;
      else if (adv) dv_v_r[i+1] <= dv_v_r[i];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_c_r[i+1]   <= dv_c_r[i];
        dv_neg_r[i+1] <= dv_neg_r[i];
      end
    end

    for (genvar j = 0; j < 4; j++) begin : g_lane
      logic ge;

      assign ge = dv_rem_r[i][j] >= dsh;

      always_ff @(posedge clk) begin
        if (adv) begin
          dv_rem_r[i+1][j] <= ge ? dv_rem_r[i][j] - dsh : dv_rem_r[i][j];
          dv_quo_r[i+1][j] <= {dv_quo_r[i][j][DQW-2:0], ge};
        end
      end
    end
  end

  // ---- F1: target coordinates
  always_ff @(posedge clk) begin
    if (!rst_n) vf1_r <= 1'b0;
    else if (adv) vf1_r <= dv_v_r[DQW];
  end

  always_ff @(posedge clk) begin
    if (adv) cf1_r <= dv_c_r[DQW];
  end

  for (genvar j = 0; j < 4; j++) begin : g_pos
    pos_t mag, base;

    assign mag  = $signed({{(PXW-DQW){1'b0}}, dv_quo_r[DQW][j]});
    assign base = (j < 2) ? pos_t'(dv_c_r[DQW].pts.rx) : pos_t'(dv_c_r[DQW].pts.ry);

    always_ff @(posedge clk) begin
      if (adv) pf1_r[j] <= dv_neg_r[DQW][j] ? base - mag : base + mag;
    end
  end

  // ---- F2: span tests and distances; s2 is the larger-x root
  pos_t    x_s1, y_s1, x_s2, y_s2;
  logic    span_c;
  status_t st_c;

  assign x_s1 = cf1_r.dxneg ? pf1_r[0] : pf1_r[1];
  assign y_s1 = cf1_r.dxneg ? pf1_r[2] : pf1_r[3];
  assign x_s2 = cf1_r.dxneg ? pf1_r[1] : pf1_r[0];
  assign y_s2 = cf1_r.dxneg ? pf1_r[3] : pf1_r[2];

  assign span_c =
    (outside(y_s1, cf1_r.pts.sy, cf1_r.pts.ey) && outside(y_s2, cf1_r.pts.sy, cf1_r.pts.ey)) ||
    (outside(x_s1, cf1_r.pts.sx, cf1_r.pts.ex) && outside(x_s2, cf1_r.pts.sx, cf1_r.pts.ex));

  always_comb begin
    if (cf1_r.nosol) st_c = ST_NO_ROOT;
    else if (span_c) st_c = ST_OUTSIDE;
    else st_c = ST_FOUND;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vf2_r <= 1'b0;
    else if (adv) vf2_r <= vf1_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stf2_r  <= st_c;
      ax_s1_r <= x_s1;
      ay_s1_r <= y_s1;
      ax_s2_r <= x_s2;
      ay_s2_r <= y_s2;
      e1_r    <= EW'(absd(cf1_r.pts.ex, x_s1)) + EW'(absd(cf1_r.pts.ey, y_s1));
      e2_r    <= EW'(absd(cf1_r.pts.ex, x_s2)) + EW'(absd(cf1_r.pts.ey, y_s2));
    end
  end

  // ---- F3: pick, saturate, output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= vf2_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_status_r <= stf2_r;
      if (stf2_r != ST_FOUND) begin
        out_tx_r <= '0;
        out_ty_r <= '0;
      end else if (e1_r < e2_r) begin
        out_tx_r <= sat(ax_s1_r);
        out_ty_r <= sat(ay_s1_r);
      end else begin
        out_tx_r <= sat(ax_s2_r);
        out_ty_r <= sat(ay_s2_r);
      end
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.target_x = out_tx_r;
  assign out_ch.target_y = out_ty_r;
  assign out_ch.status   = out_status_r;

`ifndef ASSERT_OFF
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("result valid after reset");

  a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_FOUND |-> out_tx_r == '0 && out_ty_r == '0)
    else $error("nonzero target with failure status");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable({v1_r, v2_r, v3_r, v4_r, v5_r, sq_v_r, v7_r, v8_r, v9_r,
                      dv_v_r, vf1_r, vf2_r, out_valid_r}))
    else $error("pipeline moved during stall");
`endif

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the lookahead line/circle intersection block. Directed and
// random segment queries go in, each result item is checked against an
// exact integer predictor, with random stalls on both channels and a long output stall.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import llci_pkg::*;

  localparam int  TIMEOUT_CYCLES = 2000000;
  localparam int  DRAIN_CYCLES   = 200;
  localparam longint CMAXL = (64'sd1 <<< (CW - 1)) - 1;
  localparam longint CMINL = -CMAXL - 1;
  localparam longint RMAXL = (64'sd1 <<< RS) - 1;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    coord_t  sx, sy, ex, ey, rx, ry;
    radius_t r;
  } query_t;

  typedef struct {
    coord_t  tx, ty;
    status_t st;
  } target_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  llci_in_if  in_ch ();
  llci_out_if out_ch ();

  lookahead_line_circle_intersect DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  target_t targets_due[$];
  int      errors = 0;
  int      n_sent = 0;
  int      n_checked = 0;
  int      n_status[3] = '{0, 0, 0};
  int      cycles = 0;
  int      in_idle = 0;
  int      out_idle = 0;
  int      hold_req = 0;
  int      hold_left = 0;

  function automatic longint isqrt(wide_t x);
    longint q;
    longint c;
    q = 0;
    for (int b = 55; b >= 0; b--) begin
      c = q | (64'sd1 <<< b);
      if (wide_t'(c) * wide_t'(c) <= x) q = c;
    end
    return q;
  endfunction

  function automatic longint round_div(wide_t n, longint l);
    wide_t m;
    wide_t q;
    m = (n < 0) ? -n : n;
    q = (2 * m + wide_t'(l)) / (2 * wide_t'(l));
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic bit outside(longint v, longint a, longint b);
    return (v < a && v < b) || (v > a && v > b);
  endfunction

  function automatic longint absl(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint sat(longint v);
    return v > CMAXL ? CMAXL : (v < CMINL ? CMINL : v);
  endfunction

  function automatic target_t predict_target(query_t it);
    longint  sx, sy, ex, ey, rx, ry, r, dx, dy, c, l, q, e1, e2;
    longint  px[2], py[2];
    wide_t   r2l, c2, t, nx, ny;
    int      s1, s2, pick;
    target_t res;
    res.tx = '0;
    res.ty = '0;
    res.st = ST_FOUND;
    sx = it.sx; sy = it.sy; ex = it.ex; ey = it.ey; rx = it.rx; ry = it.ry;
    r = longint'({1'b0, it.r});
    dx = ex - sx;
    dy = ey - sy;
    if (dx == 0 && dy == 0) dx = 1;
    l = dx * dx + dy * dy;
    c = (sx - rx) * dy - (sy - ry) * dx;
    r2l = wide_t'(r * r) * wide_t'(l);
    c2 = wide_t'(c) * wide_t'(c);
    if (r2l < c2) begin
      res.st = ST_NO_ROOT;
      return res;
    end
    q = isqrt(r2l - c2);
    for (int k = 0; k < 2; k++) begin
      t = wide_t'(q) * wide_t'(dx);
      nx = wide_t'(c) * wide_t'(dy) + ((k == 0) ? t : -t);
      t = wide_t'(q) * wide_t'(dy);
      ny = -(wide_t'(c) * wide_t'(dx)) + ((k == 0) ? t : -t);
      px[k] = rx + round_div(nx, l);
      py[k] = ry + round_div(ny, l);
    end
    s2 = dx >= 0 ? 0 : 1;
    s1 = 1 - s2;
    if ((outside(py[0], sy, ey) && outside(py[1], sy, ey)) ||
        (outside(px[0], sx, ex) && outside(px[1], sx, ex))) begin
      res.st = ST_OUTSIDE;
      return res;
    end
    e1 = absl(ex - px[s1]) + absl(ey - py[s1]);
    e2 = absl(ex - px[s2]) + absl(ey - py[s2]);
    pick = e1 < e2 ? s1 : s2;
    res.tx = coord_t'(sat(px[pick]));
    res.ty = coord_t'(sat(py[pick]));
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH result %0d %s: got %0d expected %0d", n_checked, what, got, want);
    errors++;
  endtask

  // predictions queued on input accept, checked on output accept
  always @(posedge clk) begin
    query_t  q;
    target_t want;
    cycles++;
    if (cycles > TIMEOUT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, targets_due.size());
      $display("** lookahead_line_circle_intersect: FAILED **");
      $finish;
    end else begin
      if (rst_n && in_ch.valid && in_ch.ready) begin
        q.sx = in_ch.start_x; q.sy = in_ch.start_y;
        q.ex = in_ch.end_x;   q.ey = in_ch.end_y;
        q.rx = in_ch.robot_x; q.ry = in_ch.robot_y;
        q.r  = in_ch.circle_radius;
        targets_due.push_back(predict_target(q));
      end
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (targets_due.size() == 0) begin
          report_mismatch("unexpected result item", 1, 0);
        end else begin
          want = targets_due.pop_front();
          if (out_ch.status != want.st)
            report_mismatch("status", out_ch.status, want.st);
          if (out_ch.target_x != want.tx)
            report_mismatch("target_x", out_ch.target_x, want.tx);
          if (out_ch.target_y != want.ty)
            report_mismatch("target_y", out_ch.target_y, want.ty);
          if (want.st <= ST_OUTSIDE) n_status[want.st]++;
        end
        n_checked++;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= out_idle);
    end
  end

  // called at a falling edge; returns at the falling edge after accept
  task automatic send_query(query_t it);
    while ($urandom_range(99) < in_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.start_x       <= it.sx;
    in_ch.start_y       <= it.sy;
    in_ch.end_x         <= it.ex;
    in_ch.end_y         <= it.ey;
    in_ch.circle_radius <= it.r;
    in_ch.robot_x       <= it.rx;
    in_ch.robot_y       <= it.ry;
    do @(posedge clk); while (!in_ch.ready);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    while (targets_due.size() != 0) @(negedge clk);
  endtask

  function automatic coord_t clampc(longint v);
    return coord_t'(sat(v));
  endfunction

  function automatic longint srand(int bits);
    return longint'($urandom_range((1 << bits) - 1)) - longint'(1 << (bits - 1));
  endfunction

  function automatic query_t make_query(longint sx, longint sy, longint ex, longint ey,
                                        longint r, longint rx, longint ry);
    query_t it;
    it.sx = clampc(sx); it.sy = clampc(sy);
    it.ex = clampc(ex); it.ey = clampc(ey);
    it.rx = clampc(rx); it.ry = clampc(ry);
    it.r  = radius_t'(r > RMAXL ? RMAXL : (r < 0 ? 0 : r));
    return it;
  endfunction

  function automatic query_t random_query();
    query_t it;
    int     mode;
    int     k;
    longint rx, ry, sx, sy;
    mode = $urandom_range(99);
    k = $urandom_range(22, 4);
    rx = srand(CW); ry = srand(CW);
    if (mode < 15) begin
      it.sx = coord_t'($urandom); it.sy = coord_t'($urandom);
      it.ex = coord_t'($urandom); it.ey = coord_t'($urandom);
      it.rx = coord_t'($urandom); it.ry = coord_t'($urandom);
      it.r  = radius_t'($urandom);
    end else if (mode < 30) begin
      sx = rx + srand(k); sy = ry + srand(k);
      case ($urandom_range(2))
        0: it = make_query(sx, sy, sx, sy + srand(k + 1), srand(k + 1) + (1 << k), rx, ry);
        1: it = make_query(sx, sy, sx + srand(k + 1), sy, srand(k + 1) + (1 << k), rx, ry);
        default: it = make_query(sx, sy, sx, sy, $urandom_range(1 << k), rx, ry);
      endcase
    end else begin
      it = make_query(rx + srand(k + 1), ry + srand(k + 1), rx + srand(k + 1),
                      ry + srand(k + 1), $urandom_range(1 << k), rx, ry);
    end
    return it;
  endfunction

  task automatic test_directed();
    query_t d[$];
    d.push_back(make_query(0, 0, 1000, 0, 500, 0, 0));
    d.push_back(make_query(100, -1000, 100, 1000, 300, 0, 0));
    d.push_back(make_query(50, 50, 50, 50, 100, 0, 0));
    d.push_back(make_query(-100, -100, 100, 100, 0, 0, 0));
    d.push_back(make_query(-100, -100, 100, 100, 0, 5, 0));
    d.push_back(make_query(-500, 200, 500, 200, 200, 0, 0));
    d.push_back(make_query(-500, 200, 500, 200, 100, 0, 0));
    d.push_back(make_query(1000, 0, 2000, 0, 100, 0, 0));
    d.push_back(make_query(0, 1000, 0, 2000, 100, 0, 0));
    d.push_back(make_query(1000, 0, -1000, 0, 300, 0, 0));
    d.push_back(make_query(-1000, 0, 0, 0, 300, 0, 0));
    d.push_back(make_query(0, -1000, 0, 0, 300, 0, 0));
    d.push_back(make_query(-300, -700, 900, 500, 450, 17, -23));
    d.push_back(make_query(CMINL, CMINL, CMAXL, CMAXL, RMAXL, 0, 0));
    d.push_back(make_query(CMAXL, CMAXL, CMINL, CMINL, RMAXL, CMINL, CMINL));
    d.push_back(make_query(CMINL, CMAXL, CMAXL, CMAXL, RMAXL, CMAXL, CMAXL));
    d.push_back(make_query(CMAXL, CMINL, CMINL, CMINL, RMAXL, CMINL, CMINL));
    d.push_back(make_query(CMINL, CMAXL, CMAXL, CMINL, RMAXL, CMAXL, CMAXL));
    d.push_back(make_query(CMAXL, CMAXL, CMAXL, CMAXL, RMAXL, CMINL, CMINL));
    d.push_back(make_query(0, 0, 0, 0, 0, 0, 0));
    foreach (d[i]) send_query(d[i]);
    wait_drain();
  endtask

  task automatic test_random(int n, int idle_in, int idle_out);
    in_idle = idle_in;
    out_idle = idle_out;
    repeat (n) send_query(random_query());
    wait_drain();
  endtask

  task automatic test_backpressure();
    in_idle = 0;
    out_idle = 0;
    hold_req = 400;
    repeat (200) send_query(random_query());
    wait_drain();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.start_x = '0; in_ch.start_y = '0; in_ch.end_x = '0; in_ch.end_y = '0;
    in_ch.circle_radius = '0; in_ch.robot_x = '0; in_ch.robot_y = '0;
    out_ch.ready = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random(520, 35, 60);
    test_random(520, 60, 35);
    test_random(520, 0, 0);
    test_backpressure();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("%0d items sent, %0d results checked: %0d found, %0d no root, %0d outside",
             n_sent, n_checked, n_status[0], n_status[1], n_status[2]);
    $display("covered extremes, vertical, degenerate, tangent, ties and long stalls");
    if (errors == 0 && targets_due.size() == 0) begin
      $display("** lookahead_line_circle_intersect: PASSED **");
    end else begin
      $display("** lookahead_line_circle_intersect: FAILED **");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/llci_pkg.sv
hw/rtl/llci_in_if.sv
hw/rtl/llci_out_if.sv
hw/rtl/lookahead_line_circle_intersect.sv
test/tb_top.sv
